// File: rtl/four_port_pad_multiplexer_assert.svh
// Assertion macros used by the checker of the pad multiplexer.
// Each macro expects i_clk and i_rst_n in scope; checks are off in reset.
`ifndef FOUR_PORT_PAD_MULTIPLEXER_ASSERT_SVH
`define FOUR_PORT_PAD_MULTIPLEXER_ASSERT_SVH

// Same-cycle implication.
`define FPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pad multiplexer check failed");

// Next-cycle implication.
`define FPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pad multiplexer check failed");

`endif

// File: rtl/fpm_pkg.sv
`default_nettype none

package fpm_pkg;

    // Stream widths.
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;
    localparam int DEV_SLOT_W  = 2;

    // Result queue geometry.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_HOST  = 2'd0,
        REQ_REPLY = 2'd1,
        REQ_END   = 2'd2
    } t_req;

    // Fixed protocol bytes.
    localparam logic [7:0] BYTE_ALL_ID    = 8'h80;
    localparam logic [7:0] BYTE_ALL_READY = 8'h5A;
    localparam logic [7:0] BYTE_READ_CMD  = 8'h42;
    localparam logic [7:0] BYTE_SEL_CARD  = 8'h81;
    localparam logic [7:0] BYTE_SEL_CTRL  = 8'h01;
    localparam logic [7:0] BYTE_CARD_BASE = 8'h80;
    localparam logic [7:0] BYTE_IDLE      = 8'hFF;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] SLOT_MASK      = 8'h0F;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] host_byte;
        logic [7:0] dev_byte;
        logic       dev_ack;
    } t_item;

    typedef struct packed {
        logic                  res_kind;
        logic [7:0]            res_byte;
        logic                  res_ack;
        logic [DEV_SLOT_W-1:0] dev_slot;
        logic                  dev_is_card;
        logic                  last;
    } t_result;

    // Up to two results produced by one item.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_core_out;

    function automatic t_result mk_reply(input logic [7:0] b, input logic ack);
        t_result r;
        r = '0;
        r.res_byte = b;
        r.res_ack  = ack;
        return r;
    endfunction

    function automatic t_result mk_fwd(input logic [7:0] b,
                                       input logic [DEV_SLOT_W-1:0] slot,
                                       input logic card);
        t_result r;
        r = '0;
        r.res_kind    = 1'b1;
        r.res_byte    = b;
        r.dev_slot    = slot;
        r.dev_is_card = card;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fpm_core.sv
`default_nettype none

module fpm_core #(
    parameter int SLOTS          = 4,
    parameter int BYTES_PER_SLOT = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire fpm_pkg::t_item    i_item,
    output fpm_pkg::t_core_out     o_res
);
    import fpm_pkg::*;

    localparam int BUF_LEN = SLOTS * BYTES_PER_SLOT;
    localparam int SW      = $clog2(BUF_LEN);
    localparam int PW      = $clog2(BYTES_PER_SLOT);
    localparam int SLW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        M_IDLE, M_CARD, M_CMD, M_SINGLE, M_ALL
    } t_mode;

    typedef enum logic [2:0] {
        P_NONE, P_RELAY, P_SEL_CARD, P_SEL_CTRL,
        P_CARD_PASS, P_SINGLE_PASS, P_FILL, P_DUMMY
    } t_pend;

    t_mode          r_mode, n_mode;
    t_pend          r_pend, n_pend;
    logic [SLW-1:0] r_cur_slot, n_cur_slot;
    logic [SW-1:0]  r_step, n_step;
    logic [PW-1:0]  r_pos, n_pos;
    logic           r_all_q, n_all_q;
    logic           r_bad, n_bad;
    logic           r_fin, n_fin;
    logic [SLW-1:0] r_dummy, n_dummy;
    logic [SW-1:0]  r_fill, n_fill;
    logic           r_fill_last, n_fill_last;

    // Pad buffer with one valid bit per entry; an unwritten entry reads 0xFF.
    logic [7:0]         r_mem [BUF_LEN];
    logic [BUF_LEN-1:0] r_vld;
    logic [7:0]         r_rd_data;
    logic               r_rd_vld;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               rd_fwd;

    // First slot at or after 'from' that is not the selected one;
    // SLOTS when there is none.
    function automatic logic [SLW:0] next_dummy(input logic [SLW:0] from,
                                                input logic [SLW-1:0] cur);
        logic [SLW:0] c;
        c = from;
        if (c == {1'b0, cur}) begin
            c = c + (SLW+1)'(1);
        end
        return c;
    endfunction

    logic [SLW:0] dz_first, dz_next;
    logic         group_end;
    logic [7:0]   b, d, rd_byte;
    logic         a;
    logic         all_ack;

    assign b         = i_item.host_byte;
    assign d         = i_item.dev_byte;
    assign a         = i_item.dev_ack;
    assign dz_first  = next_dummy('0, r_cur_slot);
    assign dz_next   = next_dummy({1'b0, r_dummy} + (SLW+1)'(1), r_cur_slot);
    assign group_end = (r_pos == PW'(BYTES_PER_SLOT - 1));
    assign rd_byte   = r_rd_vld ? r_rd_data : BYTE_IDLE;

    always_comb begin
        n_mode      = r_mode;
        n_pend      = r_pend;
        n_cur_slot  = r_cur_slot;
        n_step      = r_step;
        n_pos       = r_pos;
        n_all_q     = r_all_q;
        n_bad       = r_bad;
        n_fin       = r_fin;
        n_dummy     = r_dummy;
        n_fill      = r_fill;
        n_fill_last = r_fill_last;
        wr_en       = 1'b0;
        wr_addr     = r_step;
        wr_data     = BYTE_IDLE;
        all_ack     = 1'b1;
        o_res       = '0;
        if (i_take) begin
            case (i_item.req_type)
                REQ_HOST: begin
                    n_pend = P_NONE;
                    case (r_mode)
                        M_CARD: begin
                            o_res.r0  = mk_fwd(b, DEV_SLOT_W'(r_cur_slot), 1'b1);
                            o_res.cnt = 2'd1;
                            n_pend    = P_CARD_PASS;
                        end
                        M_CMD: begin
                            o_res.cnt = 2'd1;
                            if (r_step == '0) begin
                                if (r_all_q) begin
                                    o_res.r0 = mk_reply(BYTE_ALL_ID, 1'b1);
                                    n_bad    = (b != BYTE_READ_CMD);
                                end else begin
                                    o_res.r0 = mk_fwd(b, DEV_SLOT_W'(r_cur_slot), 1'b0);
                                    n_pend   = P_RELAY;
                                end
                                n_step = SW'(1);
                                n_pos  = PW'(1);
                            end else if (r_step == SW'(1)) begin
                                if (r_all_q) begin
                                    o_res.r0   = mk_reply(BYTE_ALL_READY, !r_bad);
                                    n_cur_slot = '0;
                                    n_mode     = M_ALL;
                                end else begin
                                    o_res.r0 = mk_fwd(BYTE_ZERO, DEV_SLOT_W'(r_cur_slot),
                                                      1'b0);
                                    n_pend   = P_RELAY;
                                    n_mode   = M_SINGLE;
                                end
                                n_all_q = b[0];
                                n_step  = '0;
                                n_pos   = '0;
                            end else begin
                                o_res.r0 = mk_reply(BYTE_IDLE, 1'b0);
                            end
                        end
                        M_SINGLE: begin
                            o_res.r0  = mk_fwd(b, DEV_SLOT_W'(r_cur_slot), 1'b0);
                            o_res.cnt = 2'd1;
                            n_pend    = P_SINGLE_PASS;
                        end
                        M_ALL: begin
                            // Hand out the stored byte and refill the same entry.
                            if (r_fin) begin
                                wr_en     = 1'b1;
                                wr_addr   = r_step;
                                wr_data   = BYTE_IDLE;
                                o_res.cnt = 2'd1;
                            end else begin
                                n_fill      = r_step;
                                n_fill_last = group_end;
                                n_pend      = P_FILL;
                                o_res.cnt   = 2'd2;
                            end
                            if (group_end) begin
                                n_fin = 1'b0;
                                n_pos = '0;
                                if (r_cur_slot == SLW'(SLOTS - 1)) begin
                                    n_cur_slot = '0;
                                    all_ack    = 1'b0;
                                end else begin
                                    n_cur_slot = r_cur_slot + SLW'(1);
                                end
                            end else begin
                                n_pos = r_pos + PW'(1);
                            end
                            n_step   = (r_step == SW'(BUF_LEN - 1)) ? '0 : r_step + SW'(1);
                            o_res.r0 = mk_reply(rd_byte, all_ack);
                            o_res.r1 = mk_fwd(b, DEV_SLOT_W'(r_cur_slot), 1'b0);
                        end
                        default: begin
                            if (b >= BYTE_SEL_CARD && b <= (BYTE_CARD_BASE + 8'(SLOTS))) begin
                                n_cur_slot = SLW'((b & SLOT_MASK) - 8'd1);
                                o_res.r0   = mk_fwd(BYTE_SEL_CARD,
                                                    DEV_SLOT_W'(SLW'((b & SLOT_MASK) - 8'd1)),
                                                    1'b1);
                                n_pend     = P_SEL_CARD;
                            end else if (b >= BYTE_SEL_CTRL && b <= 8'(SLOTS)) begin
                                n_cur_slot = SLW'(b - 8'd1);
                                o_res.r0   = mk_fwd(BYTE_SEL_CTRL,
                                                    DEV_SLOT_W'(SLW'(b - 8'd1)), 1'b0);
                                n_pend     = P_SEL_CTRL;
                            end else begin
                                o_res.r0 = mk_reply(BYTE_IDLE, 1'b0);
                            end
                            o_res.cnt = 2'd1;
                        end
                    endcase
                end
                REQ_REPLY: begin
                    n_pend = P_NONE;
                    case (r_pend)
                        P_RELAY: begin
                            o_res.r0  = mk_reply(d, a);
                            o_res.cnt = 2'd1;
                        end
                        P_SEL_CARD: begin
                            o_res.r0  = mk_reply(d, a);
                            o_res.cnt = 2'd1;
                            if (a) begin
                                n_mode = M_CARD;
                            end
                        end
                        P_SEL_CTRL: begin
                            o_res.r0  = mk_reply(d, a);
                            o_res.cnt = 2'd1;
                            if (a) begin
                                n_mode = M_CMD;
                                if (r_all_q && dz_first < (SLW+1)'(SLOTS)) begin
                                    o_res.r1  = mk_fwd(BYTE_SEL_CTRL,
                                                       DEV_SLOT_W'(dz_first), 1'b0);
                                    o_res.cnt = 2'd2;
                                    n_dummy   = SLW'(dz_first);
                                    n_pend    = P_DUMMY;
                                end
                            end
                        end
                        P_CARD_PASS, P_SINGLE_PASS: begin
                            o_res.r0  = mk_reply(d, a);
                            o_res.cnt = 2'd1;
                            if (!a) begin
                                n_mode = M_IDLE;
                            end
                        end
                        P_FILL: begin
                            wr_en   = 1'b1;
                            wr_addr = r_fill;
                            wr_data = d;
                            if (!a && !r_fill_last) begin
                                n_fin = 1'b1;
                            end
                        end
                        P_DUMMY: begin
                            if (dz_next < (SLW+1)'(SLOTS)) begin
                                o_res.r0  = mk_fwd(BYTE_SEL_CTRL, DEV_SLOT_W'(dz_next), 1'b0);
                                o_res.cnt = 2'd1;
                                n_dummy   = SLW'(dz_next);
                                n_pend    = P_DUMMY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                REQ_END: begin
                    n_mode     = M_IDLE;
                    n_cur_slot = '0;
                    n_step     = '0;
                    n_pos      = '0;
                    n_fin      = 1'b0;
                    n_pend     = P_NONE;
                end
                default: begin
                end
            endcase
            if (o_res.cnt == 2'd1) begin
                o_res.r0.last = 1'b1;
            end else if (o_res.cnt == 2'd2) begin
                o_res.r1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_pend      <= P_NONE;
            r_cur_slot  <= '0;
            r_step      <= '0;
            r_pos       <= '0;
            r_all_q     <= 1'b0;
            r_bad       <= 1'b0;
            r_fin       <= 1'b0;
            r_dummy     <= '0;
            r_fill      <= '0;
            r_fill_last <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_pend      <= n_pend;
            r_cur_slot  <= n_cur_slot;
            r_step      <= n_step;
            r_pos       <= n_pos;
            r_all_q     <= n_all_q;
            r_bad       <= n_bad;
            r_fin       <= n_fin;
            r_dummy     <= n_dummy;
            r_fill      <= n_fill;
            r_fill_last <= n_fill_last;
        end
    end

    // The entry at the next step is read ahead, so it is ready in a register
    // when the next host byte of the sweep arrives.
    assign rd_fwd = wr_en && (wr_addr == n_step);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= rd_fwd ? wr_data : r_mem[n_step];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rd_vld <= rd_fwd || r_vld[n_step];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpm_res_fifo.sv
`default_nettype none

module fpm_res_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fpm_pkg::t_core_out  i_push,
    output logic                     o_room,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output fpm_pkg::t_result         o_res
);
    import fpm_pkg::*;

    t_result            r_q [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wp, r_rp, n_wp;
    logic [RQ_AW:0]     r_cnt;
    logic [RQ_AW-1:0]   wp1;
    logic               pop;

    assign wp1     = r_wp + RQ_AW'(1);
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rp];
    assign pop     = o_valid && i_ready;
    // Space for two more results, whatever leaves this cycle.
    assign o_room  = (r_cnt <= (RQ_AW+1)'(RQ_DEPTH - 2));
    assign n_wp    = r_wp + RQ_AW'(i_push.cnt);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[wp1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= r_rp + RQ_AW'(pop);
            r_cnt <= r_cnt + (RQ_AW+1)'(i_push.cnt) - (RQ_AW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

// File: rtl/four_port_pad_multiplexer.sv
// A result passes through the input register and then the result queue before it can be taken.
// Throughput: one input transfer per cycle for items with at most one result while the output
// is not stalled; items with two results are slowed by the one-result-per-cycle output.
// Reset: synchronous, active low; clears mode, slot, step, pending reply and the queue,
// and the pad buffer reads as 0xFF in every entry until it is refilled.
`default_nettype none

module four_port_pad_multiplexer #(
    parameter int SLOTS          = 4,
    parameter int BYTES_PER_SLOT = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Bits from 0 up: host_byte[7:0], dev_byte[7:0], dev_ack, zero fill.
    input  wire logic [fpm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Bits from 0 up: req_type[1:0].
    input  wire logic [fpm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Bits from 0 up: res_byte[7:0], res_ack, dev_slot[1:0], dev_is_card, zero fill.
    output logic [fpm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // Bits from 0 up: res_kind.
    output logic [fpm_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import fpm_pkg::*;

    // The input register holds one item. The core works on it as soon as the
    // result queue has space for the two results an item may cause, and in the
    // same cycle the register can take the next transfer.
    t_item     r_in;
    logic      r_in_vld;
    logic      take;
    logic      room;
    logic      s_xfer;
    t_core_out core_res;
    t_result   q_res;

    assign take          = r_in_vld && room;
    assign s_axis_tready = !r_in_vld || take;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_xfer) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    // Payload only; it is qualified by r_in_vld.
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in.req_type  <= s_axis_tuser[1:0];
            r_in.host_byte <= s_axis_tdata[7:0];
            r_in.dev_byte  <= s_axis_tdata[15:8];
            r_in.dev_ack   <= s_axis_tdata[16];
        end
    end

    // Mode tracking, slot selection, all-pads sweep and the pad buffer.
    fpm_core #(
        .SLOTS          (SLOTS),
        .BYTES_PER_SLOT (BYTES_PER_SLOT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    // Results leave one per transfer, in the order the core produced them.
    fpm_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (q_res)
    );

    always_comb begin
        m_axis_tdata       = '0;
        m_axis_tdata[7:0]  = q_res.res_byte;
        m_axis_tdata[8]    = q_res.res_ack;
        m_axis_tdata[10:9] = q_res.dev_slot;
        m_axis_tdata[11]   = q_res.dev_is_card;
        m_axis_tuser       = OUT_TUSER_W'(q_res.res_kind);
        m_axis_tlast       = q_res.last;
    end

endmodule

`default_nettype wire

// File: rtl/fpm_checker.sv
`default_nettype none

`include "four_port_pad_multiplexer_assert.svh"

module fpm_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [fpm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic [fpm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input wire logic                               m_axis_tlast
);
    import fpm_pkg::*;

    logic stalled;
    logic out_fwd;
    logic out_reply;

    assign stalled   = m_axis_tvalid && !m_axis_tready;
    assign out_fwd   = m_axis_tvalid && m_axis_tuser[0];
    assign out_reply = m_axis_tvalid && !m_axis_tuser[0];

    // A stalled result holds until it is taken.
    `FPM_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Leaving reset, no result is offered and the input side is open.
    `FPM_ASSERT_NOW(a_reset_clean, $past(!i_rst_n), !m_axis_tvalid && s_axis_tready)

    // Bytes sent on to a device never carry the console acknowledge.
    `FPM_ASSERT_NOW(a_fwd_no_ack, out_fwd, !m_axis_tdata[8])

    // Console replies name no slot and no card.
    `FPM_ASSERT_NOW(a_reply_no_dev, out_reply, m_axis_tdata[10:9] == 2'b00 && !m_axis_tdata[11])

endmodule

bind four_port_pad_multiplexer fpm_checker u_fpm_checker (.*);

`default_nettype wire
